// ===== src/bqc_pkg.sv =====
// Shared types and constants for the biquad cascade filter.
// Holds the register map, the coefficient types and their reset values; depends on nothing.
package bqc_pkg;

  localparam int STATE_W    = 40;
  localparam int COEF_W     = 16;
  localparam int NUM_REGS   = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_FIRST_B1    = 3'd0,
    REG_FIRST_A1    = 3'd1,
    REG_FIRST_A2    = 3'd2,
    REG_SECOND_B1   = 3'd3,
    REG_SECOND_A1   = 3'd4,
    REG_SECOND_A2   = 3'd5,
    REG_OUTPUT_GAIN = 3'd6
  } bqc_reg_e;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Programmable taps of one section; b0 and b2 are fixed at one.
  typedef struct packed {
    coef_t b1;
    coef_t a1;
    coef_t a2;
  } section_coef_t;

  localparam coef_t FIRST_B1_RST    = 16'sd20062;
  localparam coef_t FIRST_A1_RST    = -16'sd5718;
  localparam coef_t FIRST_A2_RST    = 16'sd5382;
  localparam coef_t SECOND_B1_RST   = 16'sd3822;
  localparam coef_t SECOND_A1_RST   = 16'sd154;
  localparam coef_t SECOND_A2_RST   = 16'sd14783;
  localparam coef_t OUTPUT_GAIN_RST = 16'sd16384;

endpackage

// ===== src/bqc_section_cell.sv =====
// One transposed direct form II biquad section of the cascade.
// Depends on bqc_pkg for the state width and the coefficient struct.
module bqc_section_cell #(
  parameter int XW   = 24,
  parameter int FRAC = 14,
  localparam int YW  = bqc_pkg::STATE_W - FRAC + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [XW-1:0]         x_i,
  input  bqc_pkg::section_coef_t       coef_i,
  output logic                         valid_o,
  output logic signed [YW-1:0]         y_o
);
  import bqc_pkg::*;

  localparam int MW = (XW > YW) ? XW : YW;
  localparam int AW = COEF_W + MW + 3;
  localparam int RW = STATE_W + 1;
  localparam logic signed [AW-1:0] S_MAX = AW'((64'sd1 <<< (STATE_W - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] S_MIN = -S_MAX - AW'(1);

  logic signed [STATE_W-1:0]    d0_q, d0_d, d1_q, d1_d;
  logic signed [AW-1:0]         x_ext, yf_full, acc0, acc1, bx_d, bx_q;
  logic signed [STATE_W-1:0]    yf;
  logic signed [RW-1:0]         yf_rnd;
  logic signed [YW-1:0]         y_d, y_q;
  logic signed [XW-1:0]         x_q;
  logic signed [COEF_W+XW-1:0]  bx_prod;
  logic signed [COEF_W+YW-1:0]  a1y, a2y;
  logic                         busy_q;

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [AW-1:0] v);
    if (v > S_MAX) begin
      return S_MAX[STATE_W-1:0];
    end else if (v < S_MIN) begin
      return S_MIN[STATE_W-1:0];
    end
    return v[STATE_W-1:0];
  endfunction

  // Combinational on the incoming sample: output of the section and the b1 product.
  always_comb begin
    x_ext   = AW'(x_i);
    yf_full = (x_ext <<< FRAC) + AW'(d0_q);
    yf      = sat_state(yf_full);
    yf_rnd  = RW'(yf) + RW'(1 <<< (FRAC - 1));
    y_d     = yf_rnd[RW-1:FRAC];
    bx_prod = $signed(coef_i.b1) * x_i;
    bx_d    = AW'(bx_prod);
  end

  // While busy: feedback products and the delay update from the registered output.
  always_comb begin
    a1y  = $signed(coef_i.a1) * y_q;
    a2y  = $signed(coef_i.a2) * y_q;
    acc0 = bx_q - AW'(a1y) + AW'(d1_q);
    acc1 = (AW'(x_q) <<< FRAC) - AW'(a2y);
    d0_d = busy_q ? sat_state(acc0) : d0_q;
    d1_d = busy_q ? sat_state(acc1) : d1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      d0_q   <= '0;
      d1_q   <= '0;
    end else begin
      busy_q <= valid_i;
      d0_q   <= d0_d;
      d1_q   <= d1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      x_q  <= x_i;
      y_q  <= y_d;
      bx_q <= bx_d;
    end
  end

  assign valid_o = busy_q;
  assign y_o     = y_q;

`ifndef NO_ASSERTIONS
  // A new sample must never arrive while the delays of the previous one are updated.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(valid_i && busy_q))
    else $error("section cell received a sample during its delay update");
`endif

endmodule

// ===== src/bqc_gain_stage.sv =====
// Output gain, rounding and saturation to the sample range.
// Depends on bqc_pkg for the coefficient type.
module bqc_gain_stage #(
  parameter int YW   = 27,
  parameter int SW   = 24,
  parameter int FRAC = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [YW-1:0]  y_i,
  input  bqc_pkg::coef_t        gain_i,
  output logic                  valid_o,
  output logic signed [SW-1:0]  sample_o,
  output logic                  clipped_o
);
  import bqc_pkg::*;

  localparam int PW = COEF_W + YW;
  localparam int QW = PW + 1 - FRAC;
  localparam int CW = ((QW > SW) ? QW : SW) + 1;
  localparam logic signed [CW-1:0] O_MAX = CW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [CW-1:0] O_MIN = -O_MAX - CW'(1);

  logic signed [PW-1:0] prod_q;
  logic signed [PW:0]   rnd;
  logic signed [QW-1:0] q;
  logic signed [CW-1:0] q_ext;
  logic                 vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q <= $signed(gain_i) * y_i;
    end
  end

  always_comb begin
    rnd       = (PW + 1)'(prod_q) + (PW + 1)'(1 <<< (FRAC - 1));
    q         = rnd[PW:FRAC];
    q_ext     = CW'(q);
    clipped_o = 1'b0;
    if (q_ext > O_MAX) begin
      sample_o  = O_MAX[SW-1:0];
      clipped_o = 1'b1;
    end else if (q_ext < O_MIN) begin
      sample_o  = O_MIN[SW-1:0];
      clipped_o = 1'b1;
    end else begin
      sample_o  = q_ext[SW-1:0];
    end
  end

  assign valid_o = vld_q;

endmodule

// ===== src/bqc_out_queue.sv =====
// Small result queue that decouples the filter chain from the output channel.
// Standalone; uses nothing from bqc_pkg.
module bqc_out_queue #(
  parameter int W     = 25,
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [W-1:0]  data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [W-1:0]  data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  // The upstream credit count must keep the queue from ever overflowing.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> count_q != CNT_W'(DEPTH))
    else $error("result queue pushed while full");
`endif

endmodule

// ===== src/biquad_cascade_filter_unit.sv =====
// A result passes the output registers of both section cells, the gain product register and
// the result queue. Each section cell computes its output, then updates its delays from the
// rounded output; the first cell takes no new sample during that update, since the next needs them.
// Reset (asynchronous, active low) zeroes all section delays, empties the result queue and
// loads the coefficient registers with their default values; no clearing pass is needed.
module biquad_cascade_filter_unit #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 14,
  localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input request channel.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [DW-1:0]                     s_axis_tdata,   // sample_in
  // Result request channel.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [DW-1:0]                     m_axis_tdata,   // sample_out
  output logic [0:0]                        m_axis_tuser,   // clipped
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bqc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bqc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bqc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import bqc_pkg::*;

  // Width of a section output: the 40-bit state after removing the coefficient
  // fraction bits, plus one bit of headroom from round half up.
  localparam int YW = STATE_W - COEF_FRAC_BITS + 1;
  // The queue holds every result whose sample has been accepted, so its depth is
  // also the credit limit on samples in flight.
  localparam int QDEPTH = 4;
  localparam int CRED_W = $clog2(QDEPTH + 1);
  localparam int QW     = SAMPLE_WIDTH + 1;

  section_coef_t sec0_coef_q, sec1_coef_q;
  coef_t         gain_q;
  coef_t         wr_val;
  bqc_reg_e      reg_idx;
  logic          cfg_wr;

  // A write completes in the access phase; pready is tied high.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = bqc_reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign wr_val  = pwdata[COEF_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec0_coef_q <= '{b1: FIRST_B1_RST, a1: FIRST_A1_RST, a2: FIRST_A2_RST};
      sec1_coef_q <= '{b1: SECOND_B1_RST, a1: SECOND_A1_RST, a2: SECOND_A2_RST};
      gain_q      <= OUTPUT_GAIN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FIRST_B1:    sec0_coef_q.b1 <= wr_val;
        REG_FIRST_A1:    sec0_coef_q.a1 <= wr_val;
        REG_FIRST_A2:    sec0_coef_q.a2 <= wr_val;
        REG_SECOND_B1:   sec1_coef_q.b1 <= wr_val;
        REG_SECOND_A1:   sec1_coef_q.a1 <= wr_val;
        REG_SECOND_A2:   sec1_coef_q.a2 <= wr_val;
        REG_OUTPUT_GAIN: gain_q         <= wr_val;
        default: ;
      endcase
    end
  end

  // Reads return the coefficient sign-extended to the bus width; unmapped
  // addresses read as zero.
  always_comb begin
    unique case (reg_idx)
      REG_FIRST_B1:    prdata = CFG_DATA_W'(sec0_coef_q.b1);
      REG_FIRST_A1:    prdata = CFG_DATA_W'(sec0_coef_q.a1);
      REG_FIRST_A2:    prdata = CFG_DATA_W'(sec0_coef_q.a2);
      REG_SECOND_B1:   prdata = CFG_DATA_W'(sec1_coef_q.b1);
      REG_SECOND_A1:   prdata = CFG_DATA_W'(sec1_coef_q.a1);
      REG_SECOND_A2:   prdata = CFG_DATA_W'(sec1_coef_q.a2);
      REG_OUTPUT_GAIN: prdata = CFG_DATA_W'(gain_q);
      default:         prdata = '0;
    endcase
  end

  // Sample path: section cell, section cell, gain stage, result queue.
  logic                          in_acc, out_acc;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                          c0_valid, c1_valid, g_valid, g_clipped, q_valid;
  logic signed [YW-1:0]          c0_y, c1_y;
  logic signed [SAMPLE_WIDTH-1:0] g_sample;
  logic [QW-1:0]                 q_data;
  logic [CRED_W-1:0]             credit_q, credit_d;

  assign sample_in = s_axis_tdata[SAMPLE_WIDTH-1:0];

  // The first cell is busy in the cycle after it takes a sample, so among the cells it alone
  // sets the sample spacing; the credit count keeps the queue from overflowing.
  assign s_axis_tready = !c0_valid && (credit_q != CRED_W'(QDEPTH));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  always_comb begin
    credit_d = credit_q;
    if (in_acc && !out_acc) begin
      credit_d = credit_q + CRED_W'(1);
    end else if (!in_acc && out_acc) begin
      credit_d = credit_q - CRED_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  bqc_section_cell #(
    .XW   (SAMPLE_WIDTH),
    .FRAC (COEF_FRAC_BITS)
  ) u_cell0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_acc),
    .x_i     (sample_in),
    .coef_i  (sec0_coef_q),
    .valid_o (c0_valid),
    .y_o     (c0_y)
  );

  bqc_section_cell #(
    .XW   (YW),
    .FRAC (COEF_FRAC_BITS)
  ) u_cell1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c0_valid),
    .x_i     (c0_y),
    .coef_i  (sec1_coef_q),
    .valid_o (c1_valid),
    .y_o     (c1_y)
  );

  bqc_gain_stage #(
    .YW   (YW),
    .SW   (SAMPLE_WIDTH),
    .FRAC (COEF_FRAC_BITS)
  ) u_gain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (c1_valid),
    .y_i       (c1_y),
    .gain_i    (gain_q),
    .valid_o   (g_valid),
    .sample_o  (g_sample),
    .clipped_o (g_clipped)
  );

  bqc_out_queue #(
    .W     (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (g_valid),
    .data_i  ({g_clipped, g_sample}),
    .pop_i   (m_axis_tready),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  assign m_axis_tvalid = q_valid;
  assign m_axis_tdata  = DW'(q_data[SAMPLE_WIDTH-1:0]);
  assign m_axis_tuser  = q_data[QW-1];

`ifndef NO_ASSERTIONS
  // Samples in flight plus queued results never exceed the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) credit_q <= CRED_W'(QDEPTH))
    else $error("credit count above queue depth");
  // A result on the output always belongs to an accepted sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> credit_q != '0)
    else $error("result offered with no sample in flight");
  // After taking a sample, the first cell must update its delays next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> c0_valid)
    else $error("first cell missed its delay update");
`endif

endmodule
